// File: src/ppu_pkg.sv
// Package for the particle pool update unit: pool size, payload and record
// types, and the saturation helper. No dependencies.
package ppu_pkg;

	localparam int POOL_SIZE = 64;
	localparam int IDX_W = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
	localparam int SLOT_W = 6;

	localparam logic CMD_EMIT = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	// One input request.
	typedef struct packed {
		logic               command;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [15:0] dir_x;
		logic signed [15:0] dir_y;
		logic signed [31:0] speed;
		logic [15:0]        drag;
		logic [30:0]        lifetime;
		logic [15:0]        delta_time;
	} ppu_req_t;

	// One slot report.
	typedef struct packed {
		logic [SLOT_W-1:0]  slot;
		logic               alive;
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_speed;
		logic signed [31:0] out_life;
		logic               last;
	} ppu_rsp_t;

	// Particle record as held in the pool memory.
	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [15:0] dir_x;
		logic signed [15:0] dir_y;
		logic signed [31:0] speed;
		logic [15:0]        drag;
		logic signed [31:0] life;
	} ppu_rec_t;

	localparam int REC_W = $bits(ppu_rec_t);

	// Control that travels with each slot through the update pipeline.
	typedef struct packed {
		logic             valid;
		logic             live;
		logic             last;
		logic [IDX_W-1:0] slot;
	} ppu_ctl_t;

	localparam logic signed [64:0] SAT_MAX = 65'sd2147483647;
	localparam logic signed [64:0] SAT_MIN = -65'sd2147483648;

	// Clamp a wide signed value into signed 32 bits.
	function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
		logic signed [31:0] r;
		if (v > SAT_MAX) begin
			r = 32'sh7fffffff;
		end else if (v < SAT_MIN) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

// File: src/ppu_if.sv
// Valid/ready channel interfaces for requests and slot reports.
// Depends on ppu_pkg.
interface ppu_req_if import ppu_pkg::*; ;
	logic     valid;
	logic     ready;
	ppu_req_t req;
	modport source(output valid, output req, input ready);
	modport sink(input valid, input req, output ready);
endinterface

interface ppu_rsp_if import ppu_pkg::*; ;
	logic     valid;
	logic     ready;
	ppu_rsp_t rsp;
	modport source(output valid, output rsp, input ready);
	modport sink(input valid, input rsp, output ready);
endinterface

// File: src/ppu_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module ppu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read, held while re is low.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: src/particle_pool_update_unit.sv
// Top level of the particle pool update unit: pool memory, slot sequencer
// and the fixed-point Euler update pipeline. Depends on ppu_pkg, ppu_if, ppu_ram.
//
// Usage: requests arrive on req_in. An emit request writes one particle into
// the next ring slot and produces no report. A tick request walks all
// POOL_SIZE slots; each slot is read from the pool memory, updated by a
// six-stage pipeline and written back if live, and one report per slot leaves
// on rsp_out in slot order, the final one with last set.
// Throughput: one slot per cycle from the memory read port while rsp_out does
// not stall; after a tick the block takes its next request only once the last
// slot has left stage six. After an emit it stays idle and ready for the next.
// When rsp_out stalls, the whole pipeline and the slot sequencer hold, and no
// report is lost. A finished report may wait in the output register while the
// next request is taken.
// Reset clears all live flags and sets the ring index to slot zero; the pool
// memory itself is not cleared, as dead slot data never reaches a report or the pool.
module particle_pool_update_unit import ppu_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	ppu_req_if.sink   req_in,
	ppu_rsp_if.source rsp_out
);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_TICK  = 3'b010,
		ST_DRAIN = 3'b100
	} state_t;

	state_t           state_q;
	logic [IDX_W-1:0] issue_idx_q;
	logic [IDX_W-1:0] next_slot_q;
	logic [POOL_SIZE-1:0] live_q;
	logic [15:0]      dt_q;

	ppu_ctl_t c_s1, c_s2, c_s3, c_s4, c_s5, c_s6;
	ppu_rec_t rec_s2, rec_s3, rec_s4, rec_s5, rec_s6;
	logic [31:0]        dd_s2;
	logic signed [64:0] prod_s3;
	logic signed [31:0] nsp_s4, nsp_s5, nsp_s6;
	logic signed [47:0] sdt_s5;
	logic signed [63:0] stx_s6, sty_s6;

	logic     out_valid_q;
	ppu_rsp_t out_q;

	logic     adv, issue, req_acc, emit_acc, tick_acc, pipe_busy, wb_en;
	logic     ram_we;
	logic [IDX_W-1:0] ram_waddr;
	ppu_rec_t ram_wdata, ram_rdata, emit_rec, wb_rec;
	logic signed [32:0] factor;
	logic signed [31:0] new_x, new_y, new_life;

	// Handshake and pipeline advance.
	assign adv       = !out_valid_q || rsp_out.ready;
	assign issue     = (state_q == ST_TICK) && adv;
	assign req_in.ready = (state_q == ST_IDLE);
	assign req_acc   = req_in.valid && req_in.ready;
	assign emit_acc  = req_acc && (req_in.req.command == CMD_EMIT);
	assign tick_acc  = req_acc && (req_in.req.command == CMD_TICK);
	assign pipe_busy = c_s1.valid || c_s2.valid || c_s3.valid || c_s4.valid
		|| c_s5.valid || c_s6.valid;

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			issue_idx_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (tick_acc) begin
						state_q     <= ST_TICK;
						issue_idx_q <= '0;
					end
				end
				ST_TICK: begin
					if (issue) begin
						if (issue_idx_q == IDX_W'(POOL_SIZE - 1)) begin
							state_q <= ST_DRAIN;
						end else begin
							issue_idx_q <= issue_idx_q + 1'b1;
						end
					end
				end
				ST_DRAIN: begin
					if (!pipe_busy) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Time step for the running tick.
	always_ff @(posedge clk) begin
		if (tick_acc) begin
			dt_q <= req_in.req.delta_time;
		end
	end

	// Pool memory: emits write while idle, the pipeline writes back during a tick.
	always_comb begin
		emit_rec.x     = req_in.req.pos_x;
		emit_rec.y     = req_in.req.pos_y;
		emit_rec.dir_x = req_in.req.dir_x;
		emit_rec.dir_y = req_in.req.dir_y;
		emit_rec.speed = req_in.req.speed;
		emit_rec.drag  = req_in.req.drag;
		emit_rec.life  = $signed({1'b0, req_in.req.lifetime});
	end

	assign wb_en     = c_s6.valid && adv && c_s6.live;
	assign ram_we    = emit_acc || wb_en;
	assign ram_waddr = emit_acc ? next_slot_q : c_s6.slot;
	assign ram_wdata = emit_acc ? emit_rec : wb_rec;

	ppu_ram #(.WIDTH(REC_W), .DEPTH(POOL_SIZE)) u_pool (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (issue),
		.raddr(issue_idx_q),
		.rdata(ram_rdata)
	);

	// Live flags and ring index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q      <= '0;
			next_slot_q <= '0;
		end else begin
			if (emit_acc) begin
				live_q[next_slot_q] <= 1'b1;
				if (next_slot_q == IDX_W'(POOL_SIZE - 1)) begin
					next_slot_q <= '0;
				end else begin
					next_slot_q <= next_slot_q + 1'b1;
				end
			end
			if (c_s6.valid && adv) begin
				live_q[c_s6.slot] <= c_s6.live;
			end
		end
	end

	// Pipeline control; a slot with negative life is killed at stage two.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_s1 <= '0;
			c_s2 <= '0;
			c_s3 <= '0;
			c_s4 <= '0;
			c_s5 <= '0;
			c_s6 <= '0;
		end else if (adv) begin
			c_s1.valid <= issue;
			c_s1.live  <= live_q[issue_idx_q];
			c_s1.last  <= (issue_idx_q == IDX_W'(POOL_SIZE - 1));
			c_s1.slot  <= issue_idx_q;
			c_s2.valid <= c_s1.valid;
			c_s2.live  <= c_s1.live && !ram_rdata.life[31];
			c_s2.last  <= c_s1.last;
			c_s2.slot  <= c_s1.slot;
			c_s3       <= c_s2;
			c_s4       <= c_s3;
			c_s5       <= c_s4;
			c_s6       <= c_s5;
		end
	end

	assign factor = 33'sh1000000 - $signed({1'b0, dd_s2});

	// Datapath: drag*dt, speed*factor, saturate, speed*dt, direction*step.
	always_ff @(posedge clk) begin
		if (adv) begin
			rec_s2  <= ram_rdata;
			dd_s2   <= ram_rdata.drag * dt_q;
			rec_s3  <= rec_s2;
			prod_s3 <= rec_s2.speed * factor;
			rec_s4  <= rec_s3;
			nsp_s4  <= sat32(prod_s3 >>> 24);
			rec_s5  <= rec_s4;
			nsp_s5  <= nsp_s4;
			sdt_s5  <= nsp_s4 * $signed({1'b0, dt_q});
			rec_s6  <= rec_s5;
			nsp_s6  <= nsp_s5;
			stx_s6  <= rec_s5.dir_x * sdt_s5;
			sty_s6  <= rec_s5.dir_y * sdt_s5;
		end
	end

	// Final stage: position and life with saturation.
	always_comb begin
		new_x = sat32($signed({{33{rec_s6.x[31]}}, rec_s6.x})
			+ $signed({{31{stx_s6[63]}}, stx_s6[63:30]}));
		new_y = sat32($signed({{33{rec_s6.y[31]}}, rec_s6.y})
			+ $signed({{31{sty_s6[63]}}, sty_s6[63:30]}));
		new_life = sat32($signed({{33{rec_s6.life[31]}}, rec_s6.life})
			- $signed({49'b0, dt_q}));
		wb_rec       = rec_s6;
		wb_rec.x     = new_x;
		wb_rec.y     = new_y;
		wb_rec.speed = nsp_s6;
		wb_rec.life  = new_life;
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= c_s6.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q.slot      <= SLOT_W'(c_s6.slot);
			out_q.alive     <= c_s6.live;
			out_q.out_x     <= c_s6.live ? new_x : 32'sd0;
			out_q.out_y     <= c_s6.live ? new_y : 32'sd0;
			out_q.out_speed <= c_s6.live ? nsp_s6 : 32'sd0;
			out_q.out_life  <= c_s6.live ? new_life : 32'sd0;
			out_q.last      <= c_s6.last;
		end
	end

	assign rsp_out.valid = out_valid_q;
	assign rsp_out.rsp   = out_q;

endmodule

// File: src/ppu_checker.sv
// Port-level checks for the particle pool update unit, bound to the top level.
// Depends on ppu_pkg.
module ppu_checker import ppu_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     in_valid,
	input logic     in_ready,
	input ppu_req_t in_req,
	input logic     out_valid,
	input logic     out_ready,
	input ppu_rsp_t out_rsp
);

	// A held report keeps its contents.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_rsp))
		else $error("report changed while stalled");

	// The last flag marks only the final slot.
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_rsp.last |-> out_rsp.slot == SLOT_W'(POOL_SIZE - 1))
		else $error("last flag on wrong slot");

	// Dead slots report zero fields.
	a_dead: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_rsp.alive |-> out_rsp.out_x == 0 && out_rsp.out_y == 0
			&& out_rsp.out_speed == 0 && out_rsp.out_life == 0)
		else $error("dead slot with nonzero fields");

	// After a tick is taken the block is busy walking the pool.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_req.command == CMD_TICK |=> !in_ready)
		else $error("request taken during a tick");

endmodule

bind particle_pool_update_unit ppu_checker u_ppu_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (req_in.valid),
	.in_ready (req_in.ready),
	.in_req   (req_in.req),
	.out_valid(rsp_out.valid),
	.out_ready(rsp_out.ready),
	.out_rsp  (rsp_out.rsp)
);

// File: sim/ppu_checker.sv
// Checker for the particle pool update unit: watches the request and report
// channels, predicts every slot report and compares. Depends on ppu_pkg.
`timescale 1ns / 1ps

module ppu_tb_checker import ppu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	input  logic        req_ready,
	input  ppu_req_t    req,
	input  logic        rsp_valid,
	input  logic        rsp_ready,
	input  ppu_rsp_t    rsp,
	output int          fail_count,
	output int          pending
);

	// Local copy of the pool.
	logic              live_q [POOL_SIZE];
	ppu_rec_t          pool_q [POOL_SIZE];
	int                ring_idx;
	ppu_rsp_t          expected_reports [$];

	// Saturate a wide signed value into 32 bits.
	function automatic logic signed [31:0] clamp32(input logic signed [79:0] v);
		logic signed [31:0] r;
		if (v > 80'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (v < -80'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	// Apply one tick to the local pool and queue the reports it causes.
	task automatic predict_tick(input logic [15:0] dt);
		logic signed [79:0] dtw, factor, prod, sdt, stx, sty;
		logic signed [31:0] nsp;
		ppu_rsp_t r;
		dtw = $signed({64'd0, dt});
		for (int i = 0; i < POOL_SIZE; i++) begin
			if (live_q[i] && pool_q[i].life < 0) begin
				live_q[i] = 1'b0;
			end
			r = '0;
			r.slot = i[SLOT_W-1:0];
			r.last = (i == POOL_SIZE - 1);
			if (live_q[i]) begin
				factor = (80'sd1 <<< 24) - $signed({64'd0, pool_q[i].drag}) * dtw;
				prod = 80'(pool_q[i].speed) * factor;
				nsp = clamp32(prod >>> 24);
				sdt = 80'(nsp) * dtw;
				stx = (80'(pool_q[i].dir_x) * sdt) >>> 30;
				sty = (80'(pool_q[i].dir_y) * sdt) >>> 30;
				pool_q[i].life = clamp32(80'(pool_q[i].life) - dtw);
				pool_q[i].speed = nsp;
				pool_q[i].x = clamp32(80'(pool_q[i].x) + stx);
				pool_q[i].y = clamp32(80'(pool_q[i].y) + sty);
				r.alive = 1'b1;
				r.out_x = pool_q[i].x;
				r.out_y = pool_q[i].y;
				r.out_speed = pool_q[i].speed;
				r.out_life = pool_q[i].life;
			end
			expected_reports.push_back(r);
		end
	endtask

	// Track accepted requests and reports.
	always @(posedge clk or negedge arst_n) begin
		ppu_rsp_t e;
		if (!arst_n) begin
			for (int i = 0; i < POOL_SIZE; i++) begin
				live_q[i] = 1'b0;
			end
			ring_idx = 0;
			fail_count = 0;
			expected_reports.delete();
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (expected_reports.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected report, actual %p", $time, rsp);
				end else begin
					e = expected_reports.pop_front();
					if (rsp.slot !== e.slot || rsp.alive !== e.alive ||
					    rsp.out_x !== e.out_x || rsp.out_y !== e.out_y ||
					    rsp.out_speed !== e.out_speed || rsp.out_life !== e.out_life ||
					    rsp.last !== e.last) begin
						fail_count++;
						$display("%0t: report mismatch, expected %p, actual %p",
						         $time, e, rsp);
					end
				end
			end
			if (req_valid && req_ready) begin
				if (req.command == CMD_EMIT) begin
					pool_q[ring_idx].x = req.pos_x;
					pool_q[ring_idx].y = req.pos_y;
					pool_q[ring_idx].dir_x = req.dir_x;
					pool_q[ring_idx].dir_y = req.dir_y;
					pool_q[ring_idx].speed = req.speed;
					pool_q[ring_idx].drag = req.drag;
					pool_q[ring_idx].life = $signed({1'b0, req.lifetime});
					live_q[ring_idx] = 1'b1;
					ring_idx = (ring_idx + 1 >= POOL_SIZE) ? 0 : ring_idx + 1;
				end else begin
					predict_tick(req.delta_time);
				end
			end
		end
		pending = expected_reports.size();
	end

endmodule

// File: sim/particle_pool_update_unit_tb.sv
// Testbench top for the particle pool update unit: clock, reset, request stimulus
// and report back-pressure. Depends on ppu_pkg, ppu_if, ppu_tb_checker, particle_pool_update_unit.
`timescale 1ns / 1ps

module particle_pool_update_unit_tb;
	import ppu_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   cycle_count;
	bit   no_idle;
	bit   long_hold;

	ppu_req_if req_ch();
	ppu_rsp_if rsp_ch();

	particle_pool_update_unit u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.req_in  (req_ch.sink),
		.rsp_out (rsp_ch.source)
	);

	ppu_tb_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_ch.valid),
		.req_ready  (req_ch.ready),
		.req        (req_ch.req),
		.rsp_valid  (rsp_ch.valid),
		.rsp_ready  (rsp_ch.ready),
		.rsp        (rsp_ch.rsp),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog on total run length.
	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("[particle_pool_update_unit] ERROR");
				$finish;
			end
		end
	end

	// Report back-pressure: random stall bursts, one long hold on request.
	initial begin
		int n;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (long_hold) begin
				rsp_ch.ready <= 1'b0;
				repeat (300) @(posedge clk);
				long_hold = 1'b0;
				rsp_ch.ready <= 1'b1;
			end else if (!no_idle && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 18);
				rsp_ch.ready <= 1'b0;
				repeat (n) @(posedge clk);
				rsp_ch.ready <= 1'b1;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// Offer one request and hold it until it is taken; valid stays high
	// afterwards until the caller releases it or the next request idles.
	task automatic send_request(input ppu_req_t r);
		int n;
		if (!no_idle && $urandom_range(0, 4) == 0) begin
			n = $urandom_range(1, 18);
			req_ch.valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.req <= r;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	function automatic ppu_req_t random_emit();
		ppu_req_t r;
		r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		r.command = CMD_EMIT;
		case ($urandom_range(0, 3))
			0: r.lifetime = 31'($urandom_range(0, 200000));
			1: r.lifetime = 31'h7fffffff;
			default: ;
		endcase
		if ($urandom_range(0, 1)) begin
			r.speed = $signed(32'($urandom_range(0, 1 << 22))) - (1 << 21);
			r.drag = 16'($urandom_range(0, 1024));
		end
		return r;
	endfunction

	function automatic ppu_req_t tick_req(input logic [15:0] dt);
		ppu_req_t r;
		r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		r.command = CMD_TICK;
		r.delta_time = dt;
		return r;
	endfunction

	initial begin
		ppu_req_t r;
		int n;
		no_idle = 1'b0;
		long_hold = 1'b0;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.req = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: tick of an empty pool, then extreme emits.
		send_request(tick_req(16'hffff));
		r = '0;
		r.command = CMD_EMIT;
		r.pos_x = 32'sh7fffffff; r.pos_y = 32'sh80000000;
		r.dir_x = 16'sh7fff; r.dir_y = 16'sh8000;
		r.speed = 32'sh7fffffff; r.drag = 16'h0000; r.lifetime = 31'h7fffffff;
		send_request(r);
		r.pos_x = 32'sh80000000; r.pos_y = 32'sh7fffffff;
		r.dir_x = 16'sh8000; r.dir_y = 16'sh7fff;
		r.speed = 32'sh80000000; r.drag = 16'hffff; r.lifetime = 31'd0;
		send_request(r);
		r.speed = 32'sh7fffffff; r.drag = 16'hffff; r.lifetime = 31'd1;
		send_request(r);
		r.pos_x = 0; r.pos_y = 0; r.dir_x = 16'sh4000; r.dir_y = -16'sh4000;
		r.speed = 32'sh00010000; r.drag = 16'h0100; r.lifetime = 31'h00020000;
		send_request(r);
		// Ticks drive short lives negative, then kill them.
		send_request(tick_req(16'hffff));
		send_request(tick_req(16'h0000));
		send_request(tick_req(16'h8000));
		send_request(tick_req(16'hffff));

		// Fill past the ring end so slots wrap and live slots are overwritten.
		for (int i = 0; i < 70; i++) begin
			send_request(random_emit());
		end
		send_request(tick_req(16'($urandom)));
		req_ch.valid <= 1'b0;
		@(posedge clk);

		// Sender pauses until every report has arrived.
		while (pending != 0) @(posedge clk);

		// Long receiver hold while ticks keep coming.
		long_hold = 1'b1;
		send_request(tick_req(16'($urandom)));
		send_request(tick_req(16'($urandom)));

		// Random mix, mostly emits with occasional ticks.
		for (int i = 0; i < 40; i++) begin
			if (i == 30) no_idle = 1'b1;
			if ($urandom_range(0, 3) == 0) begin
				send_request(tick_req(16'($urandom)));
			end else begin
				send_request(random_emit());
			end
		end
		req_ch.valid <= 1'b0;
		@(posedge clk);

		n = 0;
		while (pending != 0 && n < 20000) begin
			@(posedge clk);
			n++;
		end
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("[particle_pool_update_unit] OK");
		end else begin
			$display("[particle_pool_update_unit] ERROR");
		end
		$finish;
	end

endmodule
